// ----- sv/cpf_pkg.sv -----
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types, constants and the CRC-16 / PN9 step functions of the framer.
// ----------------------------------------------------------------------------
package cpf_pkg;

	localparam int MaxPacketBytes = 256;

	// A packet is too long when its length byte plus three exceeds this limit (L + 3 > max)
	localparam logic [9:0] MAX_PKT = 10'(MaxPacketBytes);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8005;
	localparam logic [8:0]  PN9_SEED = 9'h1FF;

	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_PAYLOAD = 2'd1;
	localparam logic [1:0] PH_DISCARD = 2'd2;

	localparam int ResDepth = 3;

	// Result group produced by one accepted input transaction
	typedef struct packed {
		logic [1:0]                 cnt;
		logic [ResDepth-1:0][7:0]   bytes;
		logic [ResDepth-1:0]        last;
		logic [ResDepth-1:0]        err;
	} res_t;

	// Feed one byte into the CRC, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	// Advance the whitening register by eight right shifts
	function automatic logic [8:0] pn9_adv(input logic [8:0] k);
		logic [8:0] r;
		r = k;
		for (int i = 0; i < 8; i++) begin
			r = {r[5] ^ r[0], r[8:1]};
		end
		return r;
	endfunction

endpackage

// ----- sv/cpf_byte_if.sv -----
// ----------------------------------------------------------------------------
// cpf_byte_if
// Raw packet byte channel: valid/ready handshake with one data byte.
// ----------------------------------------------------------------------------
interface cpf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- sv/cpf_frame_if.sv -----
// ----------------------------------------------------------------------------
// cpf_frame_if
// Framed output channel: whitened byte with last and error marks.
// ----------------------------------------------------------------------------
interface cpf_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;
	logic       error;

	modport source (output valid, output out_byte, output last, output error, input ready);
	modport sink   (input valid, input out_byte, input last, input error, output ready);
endinterface

// ----- sv/crc16_pn9_packet_framer.sv -----
// ----------------------------------------------------------------------------
// crc16_pn9_packet_framer
// Transmit framer: CRC-16 (0x8005) append and PN9 whitening of each packet.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                    | meaning
//   --------+-----+----------------------------+-------------------------------
//   pkt     | in  | data_byte[7:0]             | length byte, then payload
//   tx      | out | out_byte[7:0], last, error | whitened bytes, CRC, error
//
// One input transaction is taken per cycle while pkt is ready; its results sit in
// a three-deep result register in the cycle after. A final payload byte (or an empty
// length byte) yields three results, so the input stalls until only the last is left.
// A discarded byte after an oversize length yields no result.
// Reset clears the packet state and drops any results not yet taken.
// A stalled tx holds the head result; pkt stays ready as long as at most the
// head result remains and it is leaving this cycle.
//
module crc16_pn9_packet_framer (
	input  logic        clk,
	input  logic        arst_n,
	cpf_byte_if.sink    pkt,
	cpf_frame_if.source tx
);
	import cpf_pkg::*;

	res_t res;
	logic load;
	logic can_load;

	// Packet state, CRC and whitening; fires load on each accepted transaction
	cpf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt      (pkt),
		.can_load (can_load),
		.load     (load),
		.res      (res)
	);

	// Result register: hold the group, advance one result per tx transaction
	cpf_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.can_load (can_load),
		.tx       (tx)
	);

endmodule

// ----- sv/cpf_core.sv -----
// ----------------------------------------------------------------------------
// cpf_core
// Packet state, CRC and whitening; builds the result group of each byte.
// ----------------------------------------------------------------------------
module cpf_core (
	input  logic           clk,
	input  logic           arst_n,
	cpf_byte_if.sink       pkt,
	input  logic           can_load,
	output logic           load,
	output cpf_pkg::res_t  res
);
	import cpf_pkg::*;

	logic [1:0]  phase_q;
	logic [7:0]  remaining_q;
	logic [15:0] crc_q;
	logic [8:0]  pn_q;

	logic        in_payload;
	logic        in_discard;
	logic        too_long;
	logic [15:0] crc_base;
	logic [8:0]  pn_base;
	logic [15:0] crc_new;
	logic [8:0]  pn1;
	logic [8:0]  pn2;
	logic [7:0]  rem_dec;
	logic        close_pkt;

	assign pkt.ready = can_load;
	assign load      = pkt.valid && can_load;

	assign in_payload = (phase_q == PH_PAYLOAD);
	assign in_discard = (phase_q == PH_DISCARD);
	assign too_long   = (10'(pkt.data_byte) + 10'd3) > MAX_PKT;

	// A length byte restarts both the CRC and the whitening sequence
	assign crc_base = in_payload ? crc_q : CRC_INIT;
	assign pn_base  = in_payload ? pn_q  : PN9_SEED;
	assign crc_new  = crc_byte(crc_base, pkt.data_byte);
	assign pn1      = pn9_adv(pn_base);
	assign pn2      = pn9_adv(pn1);
	assign rem_dec  = remaining_q - 8'd1;

	// Packet ends on an empty length byte or on the final payload byte
	assign close_pkt = in_payload ? (rem_dec == 8'd0) : (pkt.data_byte == 8'd0);

	always_comb begin
		res = '0;
		if (in_discard) begin
			res.cnt = 2'd0;
		end else if (!in_payload && too_long) begin
			res.cnt    = 2'd1;
			res.last   = 3'b001;
			res.err    = 3'b001;
		end else begin
			res.bytes[0] = pkt.data_byte ^ pn_base[7:0];
			if (close_pkt) begin
				res.cnt      = 2'd3;
				res.bytes[1] = crc_new[15:8] ^ pn1[7:0];
				res.bytes[2] = crc_new[7:0] ^ pn2[7:0];
				res.last     = 3'b100;
			end else begin
				res.cnt = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			remaining_q <= '0;
			crc_q       <= CRC_INIT;
			pn_q        <= PN9_SEED;
		end else if (load) begin
			if (in_discard) begin
				remaining_q <= rem_dec;
				if (rem_dec == 8'd0) begin
					phase_q <= PH_IDLE;
				end
			end else if (in_payload) begin
				crc_q       <= crc_new;
				pn_q        <= pn1;
				remaining_q <= rem_dec;
				if (close_pkt) begin
					phase_q <= PH_IDLE;
				end
			end else if (too_long) begin
				remaining_q <= pkt.data_byte;
				phase_q     <= (pkt.data_byte != 8'd0) ? PH_DISCARD : PH_IDLE;
			end else begin
				crc_q <= crc_new;
				pn_q  <= pn1;
				if (close_pkt) begin
					remaining_q <= '0;
					phase_q     <= PH_IDLE;
				end else begin
					remaining_q <= pkt.data_byte;
					phase_q     <= PH_PAYLOAD;
				end
			end
		end
	end

	a_discard_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DISCARD |-> remaining_q != 8'd0)
		else $error("discard phase with nothing left to drop");

	a_payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> remaining_q != 8'd0)
		else $error("payload phase with no bytes expected");

	a_phase_code: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE || phase_q == PH_PAYLOAD || phase_q == PH_DISCARD)
		else $error("packet phase holds an unused code");

endmodule

// ----- sv/cpf_outbuf.sv -----
// ----------------------------------------------------------------------------
// cpf_outbuf
// Result register: holds up to three results and hands them out one a cycle while tx is ready.
// ----------------------------------------------------------------------------
module cpf_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  cpf_pkg::res_t  res,
	output logic           can_load,
	cpf_frame_if.source    tx
);
	import cpf_pkg::*;

	logic [1:0]                cnt_q;
	logic [ResDepth-1:0][7:0]  bytes_q;
	logic [ResDepth-1:0]       last_q;
	logic [ResDepth-1:0]       err_q;
	logic                      pop;

	assign tx.valid    = (cnt_q != 2'd0);
	assign tx.out_byte = bytes_q[0];
	assign tx.last     = last_q[0];
	assign tx.error    = err_q[0];

	assign pop      = tx.valid && tx.ready;
	// Take a new group when empty, or once the head is the only result left and is leaving
	assign can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && tx.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= res.cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= res.bytes;
			last_q  <= res.last;
			err_q   <= res.err;
		end else if (pop) begin
			bytes_q <= {8'h00, bytes_q[ResDepth-1:1]};
			last_q  <= {1'b0, last_q[ResDepth-1:1]};
			err_q   <= {1'b0, err_q[ResDepth-1:1]};
		end
	end

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.error |-> tx.last && tx.out_byte == 8'h00 && cnt_q == 2'd1)
		else $error("error result is not a lone zero byte with last");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && tx.last |-> cnt_q == 2'd1)
		else $error("results queued behind a last result");

	a_load_gap: assert property (@(posedge clk) disable iff (!arst_n)
		load && res.cnt != 2'd0 |=> tx.valid)
		else $error("loaded result group not presented");

endmodule
